@@ rtl/scd_pkg.sv @@
// ----------------------------------------------------------------------------
// scd_pkg
// Shared constants and types for the serial command decoder: command codes,
// event codes, payload widths and sizes.
// ----------------------------------------------------------------------------
package scd_pkg;

    // sizes
    localparam int STRIP_LEN  = 32;
    localparam int TEXT_CHARS = 32;

    // strip buffer holds three color bytes per led
    localparam int STRIP_BYTES = 3 * STRIP_LEN;

    // payload widths
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 7;
    localparam int TEXT_W  = 5;
    localparam int COUNT_W = 7;
    localparam int SCROLL_W = 4;
    localparam int EVENT_W = 4;
    localparam int OUT_DATA_W = 40;

    // received command bytes
    localparam logic [BYTE_W-1:0] CODE_ESC   = 8'h1b;
    localparam logic [BYTE_W-1:0] MODE_IDLE  = 8'h00;
    localparam logic [BYTE_W-1:0] MODE_RELAY = 8'h11;
    localparam logic [BYTE_W-1:0] MODE_LIGHT = 8'h12;
    localparam logic [BYTE_W-1:0] MODE_TEXT  = 8'h02;
    localparam logic [BYTE_W-1:0] MODE_FILL  = 8'h13;
    localparam logic [BYTE_W-1:0] MODE_STRIP = 8'h01;
    localparam logic [BYTE_W-1:0] CHAR_ONE   = 8'h31;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;

    // input item kinds
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // scroll pattern
    localparam logic [SCROLL_W-1:0] SCROLL_FIRST = 4'b0001;
    localparam logic [SCROLL_W-1:0] SCROLL_LAST  = 4'b1000;

    // result event codes
    typedef enum logic [EVENT_W-1:0] {
        EV_NONE        = 4'd0,
        EV_RELAY_ARM   = 4'd1,
        EV_RELAY_OFF   = 4'd2,
        EV_BACKLIGHT   = 4'd3,
        EV_TEXT_CHAR   = 4'd4,
        EV_TEXT_DONE   = 4'd5,
        EV_COLOR_PART  = 4'd6,
        EV_FILL        = 4'd7,
        EV_STRIP_BYTE  = 4'd8,
        EV_DRAW        = 4'd9,
        EV_UNKNOWN     = 4'd10,
        EV_TICK        = 4'd11
    } t_event;

endpackage

@@ rtl/serial_command_decoder.sv @@
// ----------------------------------------------------------------------------
// serial_command_decoder
// Decodes received serial bytes into relay, backlight, text and led strip
// events, and runs the scroll leds and relay timer on periodic ticks.
// ----------------------------------------------------------------------------
// One input item (a received byte, or a tick when s_axis_tuser is set) gives
// exactly one result item. Items are taken one per clock cycle: the decode and
// state update is a single pass of logic from the mode state and the incoming
// item into one result register, and the result register decouples the two
// sides, so a new item is taken whenever the result register is empty or its
// result is being taken in the same cycle. The result becomes valid in the
// cycle after the input transfer. Text and strip bytes leave as indexed
// writes; the block stores none of them.
module serial_command_decoder
    import scd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [BYTE_W-1:0]     s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]            s_axis_tuser,   // [0] action
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [6:0] index, [14:7] value, [22:15] red, [30:23] green, [31] relay_out,
    // [32] lamps_out, [33] backlight_out, [37:34] scroll_leds,
    // [38] refresh_display, [39] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic [EVENT_W-1:0]    m_axis_tuser    // [3:0] event_res
);

    // decoder state
    logic [BYTE_W-1:0]   r_mode, n_mode;
    logic [TEXT_W-1:0]   r_text_count, n_text_count;
    logic [INDEX_W-1:0]  r_strip_index, n_strip_index;
    logic [BYTE_W-1:0]   r_red, n_red;
    logic [BYTE_W-1:0]   r_green, n_green;
    logic [COUNT_W-1:0]  r_relay_count, n_relay_count;
    logic                r_set_pend, n_set_pend;
    logic                r_rel_pend, n_rel_pend;
    logic                r_text_pend, n_text_pend;
    logic                r_relay, n_relay;
    logic                r_lamp, n_lamp;
    logic                r_backlight, n_backlight;
    logic [SCROLL_W-1:0] r_scroll, n_scroll;

    // result register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    t_event                r_out_event;

    // next result fields
    t_event              n_event;
    logic [INDEX_W-1:0]  n_index;
    logic [BYTE_W-1:0]   n_value;
    logic [BYTE_W-1:0]   n_out_red;
    logic [BYTE_W-1:0]   n_out_green;
    logic                n_refresh;

    logic                w_accept;
    logic [TEXT_W:0]     w_text_next;
    logic [COUNT_W-1:0]  w_count_dec;
    logic [BYTE_W-1:0]   w_byte;

    // handshake: take an item when the result slot is free or draining
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_byte        = s_axis_tdata;
    assign w_text_next   = {1'b0, r_text_count} + (TEXT_W+1)'(1);
    assign w_count_dec   = r_relay_count - COUNT_W'(1);

    // decode and state update for one item
    always_comb begin
        n_mode        = r_mode;
        n_text_count  = r_text_count;
        n_strip_index = r_strip_index;
        n_red         = r_red;
        n_green       = r_green;
        n_relay_count = r_relay_count;
        n_set_pend    = r_set_pend;
        n_rel_pend    = r_rel_pend;
        n_text_pend   = r_text_pend;
        n_relay       = r_relay;
        n_lamp        = r_lamp;
        n_backlight   = r_backlight;
        n_scroll      = r_scroll;
        n_event       = EV_NONE;
        n_index       = '0;
        n_value       = '0;
        n_out_red     = '0;
        n_out_green   = '0;
        n_refresh     = 1'b0;

        if (s_axis_tuser[0] == ACT_TICK) begin
            // rotate scroll leds
            if (r_scroll == SCROLL_LAST) begin
                n_scroll = SCROLL_FIRST;
            end else begin
                n_scroll = {r_scroll[SCROLL_W-2:0], 1'b0};
            end
            // relay timer, lamps blink while it runs
            if (r_relay_count != '0) begin
                n_relay_count = w_count_dec;
                if (w_count_dec == '0) begin
                    n_rel_pend = 1'b1;
                end else begin
                    n_lamp = !r_lamp;
                end
            end
            // completed text frame
            if (r_text_pend) begin
                n_refresh   = 1'b1;
                n_text_pend = 1'b0;
            end
            // pending relay set, then release
            if (r_set_pend) begin
                n_relay    = 1'b1;
                n_lamp     = 1'b1;
                n_set_pend = 1'b0;
            end
            if (n_rel_pend) begin
                n_relay       = 1'b0;
                n_lamp        = 1'b0;
                n_rel_pend    = 1'b0;
                n_relay_count = '0;
            end
            n_event = EV_TICK;
        end else if (w_byte == CODE_ESC) begin
            // escape returns to command select only
            n_mode = MODE_IDLE;
        end else begin
            unique case (r_mode)
                MODE_IDLE: begin
                    n_mode = w_byte;
                end
                MODE_RELAY: begin
                    if (w_byte != '0 && !w_byte[BYTE_W-1]) begin
                        n_relay_count = w_byte[COUNT_W-1:0];
                        n_set_pend    = 1'b1;
                        n_rel_pend    = 1'b0;
                        n_event       = EV_RELAY_ARM;
                    end else begin
                        n_rel_pend = 1'b1;
                        n_set_pend = 1'b0;
                        n_event    = EV_RELAY_OFF;
                    end
                    n_mode = MODE_IDLE;
                end
                MODE_LIGHT: begin
                    if (w_byte == CHAR_ONE) begin
                        n_backlight = 1'b1;
                    end else if (w_byte == CHAR_ZERO) begin
                        n_backlight = 1'b0;
                    end
                    n_event = EV_BACKLIGHT;
                    n_mode  = MODE_IDLE;
                end
                MODE_TEXT: begin
                    n_index = INDEX_W'(r_text_count);
                    n_value = w_byte;
                    if (w_text_next >= (TEXT_W+1)'(TEXT_CHARS)) begin
                        n_mode       = MODE_IDLE;
                        n_text_count = '0;
                        n_text_pend  = 1'b1;
                        n_event      = EV_TEXT_DONE;
                    end else begin
                        n_text_count = w_text_next[TEXT_W-1:0];
                        n_event      = EV_TEXT_CHAR;
                    end
                end
                MODE_FILL: begin
                    // red, green, then blue fills the strip
                    n_value = w_byte;
                    if (r_strip_index == INDEX_W'(0)) begin
                        n_red         = w_byte;
                        n_strip_index = INDEX_W'(1);
                        n_event       = EV_COLOR_PART;
                    end else if (r_strip_index == INDEX_W'(1)) begin
                        n_green       = w_byte;
                        n_strip_index = INDEX_W'(2);
                        n_event       = EV_COLOR_PART;
                    end else begin
                        n_out_red     = r_red;
                        n_out_green   = r_green;
                        n_mode        = MODE_IDLE;
                        n_strip_index = '0;
                        n_event       = EV_FILL;
                    end
                end
                MODE_STRIP: begin
                    if (r_strip_index < INDEX_W'(STRIP_BYTES)) begin
                        n_index       = r_strip_index;
                        n_value       = w_byte;
                        n_strip_index = r_strip_index + INDEX_W'(1);
                        n_event       = EV_STRIP_BYTE;
                    end else begin
                        // buffer full: this byte draws the strip
                        n_mode        = MODE_IDLE;
                        n_strip_index = '0;
                        n_event       = EV_DRAW;
                    end
                end
                default: begin
                    n_mode  = MODE_IDLE;
                    n_event = EV_UNKNOWN;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_IDLE;
            r_text_count  <= '0;
            r_strip_index <= '0;
            r_red         <= '0;
            r_green       <= '0;
            r_relay_count <= '0;
            r_set_pend    <= 1'b0;
            r_rel_pend    <= 1'b0;
            r_text_pend   <= 1'b0;
            r_relay       <= 1'b0;
            r_lamp        <= 1'b0;
            r_backlight   <= 1'b1;
            r_scroll      <= SCROLL_FIRST;
        end else if (w_accept) begin
            r_mode        <= n_mode;
            r_text_count  <= n_text_count;
            r_strip_index <= n_strip_index;
            r_red         <= n_red;
            r_green       <= n_green;
            r_relay_count <= n_relay_count;
            r_set_pend    <= n_set_pend;
            r_rel_pend    <= n_rel_pend;
            r_text_pend   <= n_text_pend;
            r_relay       <= n_relay;
            r_lamp        <= n_lamp;
            r_backlight   <= n_backlight;
            r_scroll      <= n_scroll;
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_event <= n_event;
            r_out_data  <= {1'b0, n_refresh, n_scroll, n_backlight, n_lamp, n_relay,
                            n_out_green, n_out_red, n_value, n_index};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_event;

    // scroll leds always show exactly one lit led
    a_scroll_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_scroll))
        else $error("scroll pattern lost its one-hot form");

    // a display refresh is only flagged on a tick result
    a_refresh_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != EV_TICK) |-> !m_axis_tdata[38])
        else $error("refresh flagged on a byte result");

    // after a tick no relay action is left pending unless a set arrived since
    a_tick_clears_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tuser[0] == ACT_TICK) |=> (!r_set_pend && !r_rel_pend))
        else $error("relay action still pending after a tick");

    // strip counter never passes the full buffer
    a_strip_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strip_index <= INDEX_W'(STRIP_BYTES))
        else $error("strip index beyond buffer length");

endmodule
